@@ rtl/rmq_pkg.sv @@
package rmq_pkg;

  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned NUM_ENTRIES = 9;
  localparam int unsigned IN_DATA_W = 144;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned PIV_W_BITS = 2;
  localparam int unsigned QUOT_BITS = 16;

  // pivot codes
  localparam logic [1:0] PIV_X = 2'd0;
  localparam logic [1:0] PIV_Y = 2'd1;
  localparam logic [1:0] PIV_Z = 2'd2;
  localparam logic [1:0] PIV_W = 2'd3;

  localparam logic [15:0] Q_MAX = 16'h7fff;

endpackage

@@ rtl/rotation_matrix_to_quaternion.sv @@
// Rotation matrix to unit quaternion, pipelined.
// Slave channel (s_axis_*): one word per 3x3 matrix, nine signed entries with
// FRAC_BITS fraction bits, row 0 column 0 in the lowest 16 bits.
// Master channel (m_axis_*): one word per matrix with quat x, y, z, w
// (saturated, same format) and the 2-bit pivot code (0 x, 1 y, 2 z, 3 w).
// The largest of the four trace combinations picks the pivot; its component
// is sqrt(t+1)/2 and the other three are off-diagonal terms divided by four
// times that value, rounded to nearest.
// Throughput: one matrix per cycle while the receiver does not stall. The
// depth is set by the square root, one result bit per stage on a root of
// SQW = ceil((max(FRAC_BITS,17) + FRAC_BITS) / 2) bits, and the division,
// one quotient bit per stage on four lanes.
// Reset clears all valid bits; the pipeline then comes up empty and ready.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// s_axis_tready drops in the same cycle; nothing is lost or repeated.
module rotation_matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 (16 bits each)
  input  logic [rmq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // quat_x, quat_y, quat_z, quat_w (16 bits each), pivot_case (2), zero pad
  output logic [rmq_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned VW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int unsigned YW0  = VW + FRAC_BITS - 2;
  localparam int unsigned SQW  = (YW0 + 1) / 2;
  localparam int unsigned RW   = 2 * SQW;
  localparam int unsigned REMW = SQW + 3;
  localparam int unsigned RTW  = SQW + 1;
  localparam int unsigned DENW = SQW + 3;
  localparam int unsigned NW0  = ((17 + FRAC_BITS) > (SQW + 2)) ? (17 + FRAC_BITS) : (SQW + 2);
  localparam int unsigned NW   = ((NW0 + 1) > (DENW + 16)) ? (NW0 + 1) : (DENW + 16);
  localparam int unsigned QB   = rmq_pkg::QUOT_BITS;

  logic adv;
  logic out_valid_q;
  logic [rmq_pkg::OUT_DATA_W-1:0] out_data_q;

  assign adv = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------- stage 0: input register ----------------
  logic                         in_valid_q;
  logic [rmq_pkg::IN_DATA_W-1:0] in_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_data_q <= s_axis_tdata;
    end
  end

  // ---------------- stage 1: traces and off-diagonal terms ----------------
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  assign m00 = in_data_q[15:0];
  assign m01 = in_data_q[31:16];
  assign m02 = in_data_q[47:32];
  assign m10 = in_data_q[63:48];
  assign m11 = in_data_q[79:64];
  assign m12 = in_data_q[95:80];
  assign m20 = in_data_q[111:96];
  assign m21 = in_data_q[127:112];
  assign m22 = in_data_q[143:128];

  logic signed [17:0] e00, e11, e22;
  assign e00 = 18'(m00);
  assign e11 = 18'(m11);
  assign e22 = 18'(m22);

  logic               tr_valid_q;
  logic signed [17:0] tr_q [4];
  logic signed [16:0] sxy_q, sxz_q, syz_q, dx_q, dy_q, dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_valid_q <= 1'b0;
    end else if (adv) begin
      tr_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tr_q[0] <= e00 - e11 - e22;
      tr_q[1] <= e11 - e00 - e22;
      tr_q[2] <= e22 - e00 - e11;
      tr_q[3] <= e00 + e11 + e22;
      sxy_q   <= 17'(m01) + 17'(m10);
      sxz_q   <= 17'(m20) + 17'(m02);
      syz_q   <= 17'(m12) + 17'(m21);
      dx_q    <= 17'(m12) - 17'(m21);
      dy_q    <= 17'(m20) - 17'(m02);
      dz_q    <= 17'(m01) - 17'(m10);
    end
  end

  // ---------------- stage 2: pivot, radicand, numerators ----------------
  logic [1:0]         piv_d;
  logic signed [16:0] dsel [4];
  logic [VW-1:0]      v_d;
  logic [3:0]         sgn_d;
  logic [3:0][16:0]   mag_d;

  always_comb begin
    piv_d = rmq_pkg::PIV_W;
    if (tr_q[0] > tr_q[piv_d]) piv_d = rmq_pkg::PIV_X;
    if (tr_q[1] > tr_q[piv_d]) piv_d = rmq_pkg::PIV_Y;
    if (tr_q[2] > tr_q[piv_d]) piv_d = rmq_pkg::PIV_Z;
  end

  always_comb begin
    dsel[0] = dx_q;
    dsel[1] = dy_q;
    dsel[2] = dz_q;
    dsel[3] = '0;
    case (piv_d)
      rmq_pkg::PIV_X: begin
        dsel[1] = sxy_q;
        dsel[2] = sxz_q;
        dsel[3] = dx_q;
      end
      rmq_pkg::PIV_Y: begin
        dsel[0] = sxy_q;
        dsel[2] = syz_q;
        dsel[3] = dy_q;
      end
      rmq_pkg::PIV_Z: begin
        dsel[0] = sxz_q;
        dsel[1] = syz_q;
        dsel[3] = dz_q;
      end
      default: begin
        dsel[0] = dx_q;
        dsel[1] = dy_q;
        dsel[2] = dz_q;
        dsel[3] = '0;
      end
    endcase
  end

  always_comb begin
    logic [17:0] neg_ext;
    neg_ext = '0;
    for (int l = 0; l < 4; l++) begin
      sgn_d[l] = dsel[l][16];
      neg_ext  = 18'd0 - 18'(dsel[l]);
      mag_d[l] = sgn_d[l] ? neg_ext[16:0] : 17'(dsel[l]);
    end
  end

  // pivot trace is never negative, so its low 17 bits are its value
  assign v_d = VW'(tr_q[piv_d][16:0]) + (VW'(1) << FRAC_BITS);

  // ---------------- square root: one result bit per stage ----------------
  logic             sq_valid_q [SQW+1];
  logic [1:0]       sq_piv_q   [SQW+1];
  logic [3:0]       sq_sgn_q   [SQW+1];
  logic [3:0][16:0] sq_mag_q   [SQW+1];
  logic [RW-1:0]    sq_rad_q   [SQW+1];
  logic [SQW-1:0]   sq_root_q  [SQW+1];
  logic [REMW-1:0]  sq_rem_q   [SQW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q[0] <= 1'b0;
    end else if (adv) begin
      sq_valid_q[0] <= tr_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_piv_q[0]  <= piv_d;
      sq_sgn_q[0]  <= sgn_d;
      sq_mag_q[0]  <= mag_d;
      sq_rad_q[0]  <= RW'(v_d) << (FRAC_BITS - 2);
      sq_root_q[0] <= '0;
      sq_rem_q[0]  <= '0;
    end
  end

  genvar gj;
  generate
    for (gj = 0; gj < SQW; gj++) begin : g_sqrt
      logic [REMW-1:0] cur, trial;
      logic            ge;
      assign cur   = {sq_rem_q[gj][REMW-3:0], sq_rad_q[gj][RW-1 -: 2]};
      assign trial = {1'b0, sq_root_q[gj], 2'b01};
      assign ge    = cur >= trial;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          sq_valid_q[gj+1] <= 1'b0;
        end else if (adv) begin
          sq_valid_q[gj+1] <= sq_valid_q[gj];
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv) begin
          sq_piv_q[gj+1]  <= sq_piv_q[gj];
          sq_sgn_q[gj+1]  <= sq_sgn_q[gj];
          sq_mag_q[gj+1]  <= sq_mag_q[gj];
          sq_rad_q[gj+1]  <= sq_rad_q[gj] << 2;
          sq_root_q[gj+1] <= {sq_root_q[gj][SQW-2:0], ge};
          sq_rem_q[gj+1]  <= ge ? (cur - trial) : cur;
        end
      end
    end
  endgenerate

  // ---------------- round root, form numerators ----------------
  logic [SQW-1:0]  fin_root;
  logic [REMW-1:0] fin_rem;
  logic [RTW-1:0]  rootr_d;
  assign fin_root = sq_root_q[SQW];
  assign fin_rem  = sq_rem_q[SQW];
  // remainder is y - root^2; round up when it exceeds root
  assign rootr_d  = RTW'(fin_root) + RTW'(fin_rem > REMW'(fin_root));

  logic              dv_valid_q [QB+1];
  logic [1:0]        dv_piv_q   [QB+1];
  logic [3:0]        dv_sgn_q   [QB+1];
  logic [RTW-1:0]    dv_root_q  [QB+1];
  logic [DENW-1:0]   dv_den_q   [QB+1];
  logic [3:0][NW-1:0] dv_rem_q  [QB+1];
  logic [3:0][QB-1:0] dv_quo_q  [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q[0] <= 1'b0;
    end else if (adv) begin
      dv_valid_q[0] <= sq_valid_q[SQW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_piv_q[0]  <= sq_piv_q[SQW];
      dv_sgn_q[0]  <= sq_sgn_q[SQW];
      dv_root_q[0] <= rootr_d;
      dv_den_q[0]  <= DENW'(rootr_d) << 2;
      dv_quo_q[0]  <= '0;
      for (int l = 0; l < 4; l++) begin
        dv_rem_q[0][l] <= (NW'(sq_mag_q[SQW][l]) << FRAC_BITS) + (NW'(rootr_d) << 1);
      end
    end
  end

  // ---------------- division: one quotient bit per stage ----------------
  genvar gi;
  generate
    for (gi = 0; gi < QB; gi++) begin : g_div
      logic [NW-1:0]   sh;
      logic [3:0]      ge;
      logic [3:0][NW-1:0] rem_d;
      assign sh = NW'(dv_den_q[gi]) << (QB - 1 - gi);

      always_comb begin
        for (int l = 0; l < 4; l++) begin
          ge[l]    = dv_rem_q[gi][l] >= sh;
          rem_d[l] = ge[l] ? (dv_rem_q[gi][l] - sh) : dv_rem_q[gi][l];
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dv_valid_q[gi+1] <= 1'b0;
        end else if (adv) begin
          dv_valid_q[gi+1] <= dv_valid_q[gi];
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv) begin
          dv_piv_q[gi+1]  <= dv_piv_q[gi];
          dv_sgn_q[gi+1]  <= dv_sgn_q[gi];
          dv_root_q[gi+1] <= dv_root_q[gi];
          dv_den_q[gi+1]  <= dv_den_q[gi];
          dv_rem_q[gi+1]  <= rem_d;
          for (int l = 0; l < 4; l++) begin
            dv_quo_q[gi+1][l] <= {dv_quo_q[gi][l][QB-2:0], ge[l]};
          end
        end
      end
    end
  endgenerate

  // ---------------- sign, saturate, output register ----------------
  logic [3:0][15:0] comp_d;
  logic [15:0]      root_sat;

  assign root_sat = (dv_root_q[QB] > RTW'(rmq_pkg::Q_MAX)) ? rmq_pkg::Q_MAX
                                                           : dv_root_q[QB][15:0];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (dv_sgn_q[QB][l]) begin
        // magnitude never exceeds 32768, which negates exactly
        comp_d[l] = 16'd0 - dv_quo_q[QB][l];
      end else if (dv_quo_q[QB][l] > rmq_pkg::Q_MAX) begin
        comp_d[l] = rmq_pkg::Q_MAX;
      end else begin
        comp_d[l] = dv_quo_q[QB][l];
      end
    end
    // division lane 3 carries the component of the fourth slot; swap in root
    case (dv_piv_q[QB])
      rmq_pkg::PIV_X: comp_d[0] = root_sat;
      rmq_pkg::PIV_Y: comp_d[1] = root_sat;
      rmq_pkg::PIV_Z: comp_d[2] = root_sat;
      default:        comp_d[3] = root_sat;
    endcase
  end

  // lane 3 holds the w term for x, y, z pivots; for a w pivot it is unused
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_valid_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {6'd0, dv_piv_q[QB], comp_d[3], comp_d[2], comp_d[1], comp_d[0]};
    end
  end

endmodule

@@ rtl/rmq_checker.sv @@
module rmq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rmq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

  // an empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // a full stalled output blocks the input
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted during stall");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[71:66] == 6'd0)
    else $error("pad bits set");

  // the pivot component is never negative
  a_pivot_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[65:64] == rmq_pkg::PIV_X && !m_axis_tdata[15]) ||
      (m_axis_tdata[65:64] == rmq_pkg::PIV_Y && !m_axis_tdata[31]) ||
      (m_axis_tdata[65:64] == rmq_pkg::PIV_Z && !m_axis_tdata[47]) ||
      (m_axis_tdata[65:64] == rmq_pkg::PIV_W && !m_axis_tdata[63]))
    else $error("negative pivot component");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
